// ===== hdl/vps_pkg.sv =====
`default_nettype none

package vps_pkg;

    // Lane count and word widths
    localparam int LANES = 3;
    localparam int W     = 32;
    localparam int PW    = 64;
    localparam int NW    = 96;
    localparam int QB    = 31;

    // Per-lane state of the restoring divider
    typedef struct packed {
        logic [PW-1:0] rem;
        logic [QB-1:0] num;
        logic [QB-1:0] quo;
        logic          ovf;
        logic          neg;
    } t_lane;

    // Finished result word
    typedef struct packed {
        logic [LANES-1:0][W-1:0] par;
        logic [LANES-1:0][W-1:0] perp;
        logic                    zero;
    } t_res;

    // One quotient bit: shift in the next numerator bit, compare, subtract
    function automatic t_lane div_step(input t_lane l, input logic [PW-1:0] den);
        t_lane         o;
        logic [PW:0]   r2;
        o      = l;
        r2     = {l.rem, l.num[QB-1]};
        o.num  = {l.num[QB-2:0], 1'b0};
        if (r2 >= {1'b0, den}) begin
            r2    = r2 - {1'b0, den};
            o.quo = {l.quo[QB-2:0], 1'b1};
        end else begin
            o.quo = {l.quo[QB-2:0], 1'b0};
        end
        o.rem = r2[PW-1:0];
        return o;
    endfunction

    // Apply sign and saturation to the quotient magnitude
    function automatic logic [W-1:0] lane_par(input t_lane l, input logic zero);
        logic [W-1:0] mag;
        mag = {1'b0, l.quo};
        if (zero) begin
            return '0;
        end else if (l.ovf) begin
            return l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            return l.neg ? (~mag + 32'd1) : mag;
        end
    endfunction

    // Signed a - b, saturated to 32 bits
    function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] d;
        d = {a[W-1], a} - {b[W-1], b};
        if (d[W] != d[W-1]) begin
            return d[W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return d[W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vector_projection_split.sv =====
// Splits a Q16.16 vector into its part parallel to a direction vector and
// the perpendicular remainder: par = d*(d.v)/(d.d), perp = v - par, both
// saturated to 32 bits. An all-zero direction gives par = 0, perp = v and
// sets o_dir_zero.
// Input channel: i_valid / o_ready with the six components as separate ports.
// Output channel: o_valid / i_ready with par, perp and the zero flag.
// Throughput is one word per cycle while the skid register is empty. From input
// accept to o_valid a word passes six stages of decode, 32x32 products,
// dot-product sums, sign/magnitude, partial products and the 96-bit numerator,
// then one setup stage and 31 restoring divide stages (one quotient bit each),
// then the output register. Reset clears every stage valid bit and the output
// and skid valid flags; no word is in flight afterwards.
// When the receiver stalls, the output register holds its word and a one-word
// skid register catches the word leaving the last stage; o_ready drops while
// the skid register is full and the whole pipeline holds until it drains.
`default_nettype none

module vector_projection_split
    import vps_pkg::*;
#(
    parameter int DIM = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_par_x,
    output logic signed [31:0]      o_par_y,
    output logic signed [31:0]      o_par_z,
    output logic signed [31:0]      o_perp_x,
    output logic signed [31:0]      o_perp_y,
    output logic signed [31:0]      o_perp_z,
    output logic                    o_dir_zero
);

    localparam int USED = (DIM > LANES) ? LANES : DIM;

    logic             w_en;
    logic [W-1:0]     w_vin [LANES];
    logic [W-1:0]     w_din [LANES];

    // Stage 1: magnitudes and signs
    logic             r1_vld;
    logic [W-1:0]     r1_vec [LANES];
    logic [W-1:0]     r1_vm  [LANES];
    logic [W-1:0]     r1_dm  [LANES];
    logic [LANES-1:0] r1_vn;
    logic [LANES-1:0] r1_dn;

    // Stage 2: products
    logic             r2_vld;
    logic [W-1:0]     r2_vec [LANES];
    logic [W-1:0]     r2_dm  [LANES];
    logic [LANES-1:0] r2_dn;
    logic [LANES-1:0] r2_pn;
    logic [PW-1:0]    r2_p   [LANES];
    logic [PW-1:0]    r2_dd  [LANES];

    // Stage 3: dot-product sums
    logic             r3_vld;
    logic [W-1:0]     r3_vec [LANES];
    logic [W-1:0]     r3_dm  [LANES];
    logic [LANES-1:0] r3_dn;
    logic [PW-1:0]    r3_pos;
    logic [PW-1:0]    r3_neg;
    logic [PW-1:0]    r3_q;
    logic [PW-1:0]    n_pos;
    logic [PW-1:0]    n_neg;
    logic [PW-1:0]    n_q;

    // Stage 4: signed dot product as sign and magnitude
    logic             r4_vld;
    logic [W-1:0]     r4_vec [LANES];
    logic [W-1:0]     r4_dm  [LANES];
    logic [LANES-1:0] r4_lneg;
    logic [PW-1:0]    r4_sm;
    logic [PW-1:0]    r4_q;
    logic             r4_zero;

    // Stage 5: partial products of d_i * |S|
    logic             r5_vld;
    logic [W-1:0]     r5_vec [LANES];
    logic [LANES-1:0] r5_lneg;
    logic [PW-1:0]    r5_plo [LANES];
    logic [PW-1:0]    r5_phi [LANES];
    logic [PW-1:0]    r5_q;
    logic             r5_zero;

    // Stage 6: 96-bit numerator
    logic             r6_vld;
    logic [W-1:0]     r6_vec [LANES];
    logic [LANES-1:0] r6_lneg;
    logic [NW-1:0]    r6_num [LANES];
    logic [PW-1:0]    r6_q;
    logic             r6_zero;

    // Divider stages: index 0 is setup, index k holds k quotient bits;
    // the divisor is only needed up to the stage before the last
    logic [QB:0]      r_dv_vld;
    t_lane            r_dv_lane [QB+1][LANES];
    logic [W-1:0]     r_dv_vec  [QB+1][LANES];
    logic [PW-1:0]    r_dv_den  [QB];
    logic             r_dv_zero [QB+1];

    // Output and skid registers
    logic             r_ov;
    logic             r_skv;
    t_res             r_out;
    t_res             r_skd;
    t_res             w_fin;
    logic             w_arrive;
    logic             w_take;

    assign w_en    = !r_skv;
    assign o_ready = w_en;

    assign w_vin[0] = i_vec_x;
    assign w_vin[1] = i_vec_y;
    assign w_vin[2] = i_vec_z;
    assign w_din[0] = i_dir_x;
    assign w_din[1] = i_dir_y;
    assign w_din[2] = i_dir_z;

    // Sum the signed lane products and the direction norm
    always_comb begin
        n_pos = '0;
        n_neg = '0;
        n_q   = '0;
        for (int i = 0; i < LANES; i++) begin
            if (r2_pn[i]) begin
                n_neg = n_neg + r2_p[i];
            end else begin
                n_pos = n_pos + r2_p[i];
            end
            n_q = n_q + r2_dd[i];
        end
    end

    // Finish: sign, saturate, subtract from the vector
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_fin.par[i]  = lane_par(r_dv_lane[QB][i], r_dv_zero[QB]);
            w_fin.perp[i] = sat_sub(r_dv_vec[QB][i], w_fin.par[i]);
        end
        w_fin.zero = r_dv_zero[QB];
    end

    assign w_arrive = w_en && r_dv_vld[QB];
    assign w_take   = !r_ov || i_ready;

    // Valid bits and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_vld   <= 1'b0;
            r4_vld   <= 1'b0;
            r5_vld   <= 1'b0;
            r6_vld   <= 1'b0;
            r_dv_vld <= '0;
            r_ov     <= 1'b0;
            r_skv    <= 1'b0;
        end else begin
            if (w_en) begin
                r1_vld   <= i_valid;
                r2_vld   <= r1_vld;
                r3_vld   <= r2_vld;
                r4_vld   <= r3_vld;
                r5_vld   <= r4_vld;
                r6_vld   <= r5_vld;
                r_dv_vld <= {r_dv_vld[QB-1:0], r6_vld};
            end
            if (w_take) begin
                r_ov  <= r_skv || w_arrive;
                r_skv <= 1'b0;
            end else if (w_arrive) begin
                r_skv <= 1'b1;
            end
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < LANES; i++) begin
                // decode, dropping lanes beyond the used dimension
                if (i < USED) begin
                    r1_vec[i] <= w_vin[i];
                    r1_vn[i]  <= w_vin[i][W-1];
                    r1_dn[i]  <= w_din[i][W-1];
                    r1_vm[i]  <= w_vin[i][W-1] ? (~w_vin[i] + 32'd1) : w_vin[i];
                    r1_dm[i]  <= w_din[i][W-1] ? (~w_din[i] + 32'd1) : w_din[i];
                end else begin
                    r1_vec[i] <= '0;
                    r1_vn[i]  <= 1'b0;
                    r1_dn[i]  <= 1'b0;
                    r1_vm[i]  <= '0;
                    r1_dm[i]  <= '0;
                end

                // products
                r2_vec[i] <= r1_vec[i];
                r2_dm[i]  <= r1_dm[i];
                r2_dn[i]  <= r1_dn[i];
                r2_pn[i]  <= r1_vn[i] ^ r1_dn[i];
                r2_p[i]   <= PW'(r1_vm[i]) * PW'(r1_dm[i]);
                r2_dd[i]  <= PW'(r1_dm[i]) * PW'(r1_dm[i]);

                // sums
                r3_vec[i] <= r2_vec[i];
                r3_dm[i]  <= r2_dm[i];
                r3_dn[i]  <= r2_dn[i];

                // sign and magnitude
                r4_vec[i]  <= r3_vec[i];
                r4_dm[i]   <= r3_dm[i];
                r4_lneg[i] <= r3_dn[i] ^ (r3_pos < r3_neg);

                // partial products
                r5_vec[i]  <= r4_vec[i];
                r5_lneg[i] <= r4_lneg[i];
                r5_plo[i]  <= PW'(r4_dm[i]) * PW'(r4_sm[W-1:0]);
                r5_phi[i]  <= PW'(r4_dm[i]) * PW'(r4_sm[PW-1:W]);

                // numerator
                r6_vec[i]  <= r5_vec[i];
                r6_lneg[i] <= r5_lneg[i];
                r6_num[i]  <= NW'(r5_plo[i]) + {r5_phi[i], 32'd0};

                // divider setup: quotient of 2^31 or more saturates
                r_dv_vec[0][i]      <= r6_vec[i];
                r_dv_lane[0][i].ovf <= r6_num[i][NW-1:QB] >= {1'b0, r6_q};
                r_dv_lane[0][i].rem <= r6_num[i][NW-2:QB];
                r_dv_lane[0][i].num <= r6_num[i][QB-1:0];
                r_dv_lane[0][i].quo <= '0;
                r_dv_lane[0][i].neg <= r6_lneg[i];
            end

            r3_pos <= n_pos;
            r3_neg <= n_neg;
            r3_q   <= n_q;

            r4_sm   <= (r3_pos < r3_neg) ? (r3_neg - r3_pos) : (r3_pos - r3_neg);
            r4_q    <= r3_q;
            r4_zero <= (r3_q == '0);

            r5_q    <= r4_q;
            r5_zero <= r4_zero;

            r6_q    <= r5_q;
            r6_zero <= r5_zero;

            r_dv_den[0]  <= r6_q;
            r_dv_zero[0] <= r6_zero;

            // carry the divisor along the stages that still divide
            for (int k = 1; k < QB; k++) begin
                r_dv_den[k] <= r_dv_den[k-1];
            end

            // one quotient bit per stage
            for (int k = 1; k <= QB; k++) begin
                r_dv_zero[k] <= r_dv_zero[k-1];
                for (int i = 0; i < LANES; i++) begin
                    r_dv_vec[k][i]  <= r_dv_vec[k-1][i];
                    r_dv_lane[k][i] <= div_step(r_dv_lane[k-1][i], r_dv_den[k-1]);
                end
            end
        end
    end

    // Load the output word and catch a word in the skid register on stall
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_skv ? r_skd : w_fin;
        end
        if (!w_take && w_arrive) begin
            r_skd <= w_fin;
        end
    end

    assign o_valid    = r_ov;
    assign o_par_x    = r_out.par[0];
    assign o_par_y    = r_out.par[1];
    assign o_par_z    = r_out.par[2];
    assign o_perp_x   = r_out.perp[0];
    assign o_perp_y   = r_out.perp[1];
    assign o_perp_z   = r_out.perp[2];
    assign o_dir_zero = r_out.zero;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skv |-> r_ov)
        else $error("skid register full while output register empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skv) |-> $past(r_ov && !i_ready))
        else $error("skid register loaded without a stalled output");

    a_zero_dir_par: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dir_zero) |-> (o_par_x == 0 && o_par_y == 0 && o_par_z == 0))
        else $error("nonzero parallel part with zero direction");
`endif

endmodule

`default_nettype wire

// ===== test/vector_projection_split_check.sv =====
`default_nettype none

module vector_projection_split_check
    import vps_pkg::*;
#(
    parameter int DIM = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic signed [31:0] i_dir_x,
    input  wire logic signed [31:0] i_dir_y,
    input  wire logic signed [31:0] i_dir_z,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] i_par_x,
    input  wire logic signed [31:0] i_par_y,
    input  wire logic signed [31:0] i_par_z,
    input  wire logic signed [31:0] i_perp_x,
    input  wire logic signed [31:0] i_perp_y,
    input  wire logic signed [31:0] i_perp_z,
    input  wire logic               i_dir_zero,
    output int                      o_mismatches,
    output int                      o_outstanding
);

    t_res expected_splits[$];
    int   mismatch_count    = 0;
    int   outstanding_count = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding_count;

    // Clamp a wide signed value to the 32-bit range
    function automatic logic [W-1:0] clamp32(input logic signed [127:0] x);
        if (x > 128'sh7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        if (x < -128'sh8000_0000) begin
            return 32'h8000_0000;
        end
        return x[W-1:0];
    endfunction

    // Parallel part d*(d.v)/(d.d), truncated toward zero; perp = v - par
    function automatic t_res split_projection(input logic [LANES-1:0][W-1:0] vin,
                                              input logic [LANES-1:0][W-1:0] din);
        t_res                r;
        logic signed [127:0] dv;
        logic signed [127:0] vv;
        logic signed [127:0] dot_dv;
        logic signed [127:0] dot_dd;
        logic signed [127:0] par;
        int                  used;
        int                  i;
        used   = (DIM > LANES) ? LANES : DIM;
        r      = '0;
        dot_dv = '0;
        dot_dd = '0;
        for (i = 0; i < used; i++) begin
            dv     = $signed(din[i]);
            vv     = $signed(vin[i]);
            dot_dv = dot_dv + dv * vv;
            dot_dd = dot_dd + dv * dv;
        end
        r.zero = (dot_dd == 0);
        // Lanes past the used count stay zero
        for (i = 0; i < used; i++) begin
            dv = $signed(din[i]);
            vv = $signed(vin[i]);
            if (r.zero) begin
                par = '0;
            end else begin
                par = (dv * dot_dv) / dot_dd;
            end
            r.par[i]  = clamp32(par);
            par       = $signed(r.par[i]);
            r.perp[i] = clamp32(vv - par);
        end
        return r;
    endfunction

    // Predict on each accepted input word, compare on each accepted output word
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        t_res predicted;
        int   errs;
        int   i;
        errs = mismatch_count;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                got.par[0]  = i_par_x;
                got.par[1]  = i_par_y;
                got.par[2]  = i_par_z;
                got.perp[0] = i_perp_x;
                got.perp[1] = i_perp_y;
                got.perp[2] = i_perp_z;
                got.zero    = i_dir_zero;
                if (expected_splits.size() == 0) begin
                    $display("%0t: unexpected word par %h %h %h perp %h %h %h zero %b, expected none",
                             $time, got.par[0], got.par[1], got.par[2],
                             got.perp[0], got.perp[1], got.perp[2], got.zero);
                    errs++;
                end else begin
                    want = expected_splits.pop_front();
                    for (i = 0; i < LANES; i++) begin
                        if (got.par[i] !== want.par[i]) begin
                            $display("%0t: par[%0d] expected %h, got %h",
                                     $time, i, want.par[i], got.par[i]);
                            errs++;
                        end
                        if (got.perp[i] !== want.perp[i]) begin
                            $display("%0t: perp[%0d] expected %h, got %h",
                                     $time, i, want.perp[i], got.perp[i]);
                            errs++;
                        end
                    end
                    if (got.zero !== want.zero) begin
                        $display("%0t: dir_zero expected %b, got %b",
                                 $time, want.zero, got.zero);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted = split_projection({i_vec_z, i_vec_y, i_vec_x},
                                             {i_dir_z, i_dir_y, i_dir_x});
                expected_splits = {expected_splits, predicted};
            end
        end
        mismatch_count    <= errs;
        outstanding_count <= expected_splits.size();
    end

endmodule

`default_nettype wire

// ===== test/vector_projection_split_test.sv =====
`default_nettype none

module vector_projection_split_test;
    import vps_pkg::*;

    localparam int           DIM          = 3;
    localparam int           RANDOM_WORDS = 1750;
    localparam int           DRAIN_CYCLES = 80;
    localparam logic [W-1:0] MAXV         = 32'h7FFF_FFFF;
    localparam logic [W-1:0] MINV         = 32'h8000_0000;
    localparam logic [W-1:0] ONE          = 32'h0001_0000;
    localparam logic [W-1:0] NEG1         = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_RUNS, RX_ALTERNATE} t_rx_mode;
    typedef enum int {
        SH_GENERIC, SH_ZERO_DIR, SH_PARALLEL, SH_AXIS, SH_SMALL, SH_SPARSE, SH_EXTREME
    } t_shape;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               i_valid  = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_vec_x  = '0;
    logic signed [31:0] i_vec_y  = '0;
    logic signed [31:0] i_vec_z  = '0;
    logic signed [31:0] i_dir_x  = '0;
    logic signed [31:0] i_dir_y  = '0;
    logic signed [31:0] i_dir_z  = '0;
    logic               o_valid;
    logic               i_ready  = 1'b0;
    logic signed [31:0] o_par_x;
    logic signed [31:0] o_par_y;
    logic signed [31:0] o_par_z;
    logic signed [31:0] o_perp_x;
    logic signed [31:0] o_perp_y;
    logic signed [31:0] o_perp_z;
    logic               o_dir_zero;
    int                 mismatches;
    int                 outstanding;
    int                 rx_cycle = 0;
    int                 rx_hold  = 0;

    vector_projection_split #(.DIM(DIM)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_vec_x   (i_vec_x),
        .i_vec_y   (i_vec_y),
        .i_vec_z   (i_vec_z),
        .i_dir_x   (i_dir_x),
        .i_dir_y   (i_dir_y),
        .i_dir_z   (i_dir_z),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_par_x   (o_par_x),
        .o_par_y   (o_par_y),
        .o_par_z   (o_par_z),
        .o_perp_x  (o_perp_x),
        .o_perp_y  (o_perp_y),
        .o_perp_z  (o_perp_z),
        .o_dir_zero(o_dir_zero)
    );

    vector_projection_split_check #(.DIM(DIM)) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_dir_z      (i_dir_z),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_par_x      (o_par_x),
        .i_par_y      (o_par_y),
        .i_par_z      (o_par_z),
        .i_perp_x     (o_perp_x),
        .i_perp_y     (o_perp_y),
        .i_perp_z     (o_perp_z),
        .i_dir_zero   (o_dir_zero),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always #5 i_clk = ~i_clk;

    // Stall the receiver on a pattern selected by bits 10:9 of the cycle counter
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case (t_rx_mode'(rx_cycle[10:9]))
            RX_OPEN: begin
                i_ready <= 1'b1;
            end
            RX_RANDOM: begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
            RX_RUNS: begin
                if (rx_hold > 0) begin
                    rx_hold <= rx_hold - 1;
                end else begin
                    i_ready <= ~i_ready;
                    rx_hold <= i_ready ? $urandom_range(1, 16) : $urandom_range(1, 8);
                end
            end
            default: begin
                i_ready <= rx_cycle[0];
            end
        endcase
    end

    // Present one word and hold it until accepted
    task automatic send_word(input logic [W-1:0] vx, input logic [W-1:0] vy,
                             input logic [W-1:0] vz, input logic [W-1:0] dx,
                             input logic [W-1:0] dy, input logic [W-1:0] dz);
        i_vec_x <= vx;
        i_vec_y <= vy;
        i_vec_z <= vz;
        i_dir_x <= dx;
        i_dir_y <= dy;
        i_dir_z <= dz;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Mix of full-range, small, and boundary component values
    function automatic logic [W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom;
            3, 4:    return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return ONE;
                    2:       return NEG1;
                    3:       return MAXV;
                    default: return MINV;
                endcase
            end
        endcase
    endfunction

    task automatic make_item(output logic [LANES-1:0][W-1:0] v,
                             output logic [LANES-1:0][W-1:0] d);
        t_shape shape;
        int     k;
        int     i;
        if ($urandom_range(0, 2) == 0) begin
            shape = SH_GENERIC;
        end else begin
            shape = t_shape'($urandom_range(SH_GENERIC, SH_EXTREME));
        end
        for (i = 0; i < LANES; i++) begin
            v[i] = rand_comp();
            d[i] = rand_comp();
        end
        case (shape)
            SH_ZERO_DIR: begin
                d = '0;
            end
            SH_PARALLEL: begin
                // Vector is an integer multiple of a small direction
                k = $urandom_range(0, 16) - 8;
                for (i = 0; i < LANES; i++) begin
                    d[i] = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
                    v[i] = $signed(d[i]) * k;
                end
            end
            SH_AXIS: begin
                d       = '0;
                d[$urandom_range(0, LANES - 1)] = $urandom;
            end
            SH_SMALL: begin
                for (i = 0; i < LANES; i++) begin
                    v[i] = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
                    d[i] = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
                end
            end
            SH_SPARSE: begin
                for (i = 0; i < LANES; i++) begin
                    d[i] = $urandom_range(0, 1) ? $urandom : '0;
                end
            end
            SH_EXTREME: begin
                for (i = 0; i < LANES; i++) begin
                    v[i] = $urandom_range(0, 1) ? MAXV : MINV;
                    d[i] = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? MAXV : MINV)
                                                : $urandom_range(0, 3) - 1;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Reset, directed words, then random bursts
    initial begin
        logic [LANES-1:0][W-1:0] v;
        logic [LANES-1:0][W-1:0] d;
        int                      burst_left;
        int                      k;
        burst_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero direction, with zero and extreme vectors
        send_word('0, '0, '0, '0, '0, '0);
        send_word(MAXV, MINV, 32'd1, '0, '0, '0);
        // Unit axes and a diagonal direction
        send_word(32'h0001_8000, 32'h0002_0000, 32'h0003_0000, ONE, '0, '0);
        send_word(32'h0001_8000, 32'h0002_0000, 32'h0003_0000, '0, ONE, '0);
        send_word(32'h0001_8000, 32'h0002_0000, 32'h0003_0000, ONE, ONE, ONE);
        // Full-scale operands
        send_word(MAXV, MAXV, MAXV, 32'd1, 32'd1, 32'd1);
        send_word(MINV, MINV, MINV, MINV, MINV, MINV);
        send_word(MAXV, MAXV, MAXV, MINV, MINV, MINV);
        // Parallel part saturates high and low
        send_word(MAXV, MAXV, '0, 32'd2, 32'd1, '0);
        send_word(MINV, MINV, '0, 32'd2, 32'd1, '0);
        // Perpendicular part saturates low and high
        send_word(MINV, MAXV, MAXV, 32'd1, 32'd2, 32'd2);
        send_word(MAXV, MINV, MINV, 32'd1, 32'd2, 32'd2);
        // Truncation toward zero on tiny quotients
        send_word(32'd1, 32'd1, 32'd1, MAXV, MAXV, MAXV);
        send_word(NEG1, '0, '0, 32'd3, '0, '0);
        send_word(32'd1, '0, '0, 32'd3, 32'd1, '0);
        send_word(NEG1, '0, '0, 32'd3, 32'd1, '0);
        // Orthogonal vector and zero vector
        send_word(ONE, '0, '0, '0, '0, ONE);
        send_word('0, '0, '0, MINV, '0, '0);
        send_word(32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_0F0F,
                  32'h0765_4321, 32'h8000_0001, NEG1);
        // Single-lsb directions reaching the range limits
        send_word(MINV, MINV, MINV, 32'd1, '0, '0);
        send_word(MINV, '0, '0, NEG1, '0, '0);
        send_word(MAXV, MAXV, MAXV, '0, '0, NEG1);

        // Hold off until the pipeline drains
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        burst_left = $urandom_range(1, 16);

        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (outstanding != 0) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
            // Words 600..799 go back to back with no sender gaps
            if (k < 600 || k >= 800) begin
                if (burst_left == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;
            end
            make_item(v, d);
            send_word(v[0], v[1], v[2], d[0], d[1], d[2]);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
